// ===== sv/rbts_pkg.sv =====
// rbts_pkg: shared types, register codes and helpers of the rolling band trade signal block
`timescale 1ns / 1ps

package rbts_pkg;

  // fixed field widths
  localparam int WLEN_BITS     = 7;
  localparam int LIMIT_BITS    = 10;
  localparam int MULT_BITS     = 4;
  localparam int POS_BITS      = 11;
  localparam int BAL_BITS      = 48;
  localparam int P2_BITS       = 2 * MULT_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POS_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_MULT  = 2'd2;

  // configuration reset values
  localparam logic [WLEN_BITS-1:0]  WLEN_RESET  = 7'd5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd5;
  localparam logic [MULT_BITS-1:0]  MULT_RESET  = 4'd3;

  // trade action codes
  typedef enum logic [1:0] {
    ACT_HOLD = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  // sequencer to window store control
  typedef struct packed {
    logic load;     // latch price, read oldest slot
    logic update;   // commit running sums and pointers
    logic restart;  // empty the window
  } win_ctl_t;

  // clamp a 49-bit signed value into the 48-bit balance range
  function automatic logic signed [BAL_BITS-1:0] sat_bal(input logic signed [BAL_BITS:0] v);
    logic signed [BAL_BITS-1:0] res;
    begin
      if (v[BAL_BITS] != v[BAL_BITS-1]) begin
        res = v[BAL_BITS] ? {1'b1, {(BAL_BITS-1){1'b0}}} : {1'b0, {(BAL_BITS-1){1'b1}}};
      end else begin
        res = v[BAL_BITS-1:0];
      end
      return res;
    end
  endfunction

endpackage

// ===== sv/rbts_ram.sv =====
// rbts_ram: generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module rbts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ===== sv/rbts_window.sv =====
// rbts_window: ring store of recent prices with running sum and sum of squares
`timescale 1ns / 1ps

module rbts_window #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  rbts_pkg::win_ctl_t                          ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]             n,
  input  logic [PRICE_BITS-1:0]                       price,
  output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0]    sum,
  output logic [2*PRICE_BITS+$clog2(MAX_WINDOW)-1:0]  sum_sq,
  output logic                                        ready
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int NW = $clog2(MAX_WINDOW + 1);
  localparam int SW = PRICE_BITS + AW;
  localparam int QW = 2 * PRICE_BITS + AW;
  localparam int PW = 2 * PRICE_BITS;

  logic [AW-1:0]         ptr_r;
  logic [NW-1:0]         fill_r;
  logic [SW-1:0]         sum_r;
  logic [QW-1:0]         sum_sq_r;
  logic                  ready_r;
  logic                  sq_r;
  logic                  full_r;
  logic [AW-1:0]         slot_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [PRICE_BITS-1:0] old_r;
  logic [PW-1:0]         old_sq_r;
  logic [PW-1:0]         new_sq_r;
  logic [AW-1:0]         slot;
  logic [PRICE_BITS-1:0] rdata;
  logic [PRICE_BITS-1:0] old;
  logic [NW:0]           ptr_inc;

  // slot to overwrite, wrapping if the pointer ran past the window
  assign slot    = ((NW+1)'(ptr_r) >= (NW+1)'(n)) ? '0 : ptr_r;
  assign old     = full_r ? rdata : '0;
  assign ptr_inc = (NW+1)'(slot_r) + (NW+1)'(1);

  rbts_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (sq_r),
    .waddr (slot_r),
    .wdata (price_r),
    .raddr (slot),
    .rdata (rdata)
  );

  // word capture and squaring stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      slot_r  <= slot;
      price_r <= price;
      full_r  <= fill_r >= n;
    end
    if (sq_r) begin
      old_r    <= old;
      old_sq_r <= PW'(old) * PW'(old);
      new_sq_r <= PW'(price_r) * PW'(price_r);
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      sum_sq_r <= '0;
      ready_r  <= 1'b0;
      sq_r     <= 1'b0;
    end else begin
      sq_r <= ctl.load;
      if (ctl.restart) begin
        ptr_r    <= '0;
        fill_r   <= '0;
        sum_r    <= '0;
        sum_sq_r <= '0;
        ready_r  <= 1'b0;
      end else if (ctl.update) begin
        sum_r    <= sum_r - SW'(old_r) + SW'(price_r);
        sum_sq_r <= sum_sq_r - QW'(old_sq_r) + QW'(new_sq_r);
        if (!full_r) begin
          fill_r <= fill_r + NW'(1);
        end
        ptr_r   <= (ptr_inc >= (NW+1)'(n)) ? '0 : ptr_inc[AW-1:0];
        ready_r <= full_r || (((NW+1)'(fill_r) + (NW+1)'(1)) >= (NW+1)'(n));
      end
    end
  end

  assign sum    = sum_r;
  assign sum_sq = sum_sq_r;
  assign ready  = ready_r;

  // fill count never passes the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= n)
    else $error("window fill count above window length");

  // after an update the write pointer lies inside the window
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.update && !ctl.restart) |=> ((NW+1)'(ptr_r) < (NW+1)'($past(n))))
    else $error("write pointer outside window");

endmodule

// ===== sv/rbts_band.sv =====
// rbts_band: staged exact band test in squared integer form
`timescale 1ns / 1ps

module rbts_band #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]             n,
  input  logic [PRICE_BITS-1:0]                       price,
  input  logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0]    sum,
  input  logic [2*PRICE_BITS+$clog2(MAX_WINDOW)-1:0]  sum_sq,
  input  logic [rbts_pkg::MULT_BITS-1:0]              mult,
  output logic                                        done,
  output logic                                        dpos,
  output logic                                        hit
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int SW = PRICE_BITS + AW;
  localparam int DW = 2 * SW;
  localparam int RW = DW + rbts_pkg::P2_BITS;
  localparam int PB = rbts_pkg::P2_BITS;

  logic [3:0]    vld_r;
  logic [SW-1:0] np_r;
  logic [DW-1:0] nq_r;
  logic [DW-1:0] s2_r;
  logic [PB-1:0] p2_r;
  logic          dpos_r;
  logic [SW-1:0] mag_r;
  logic [DW-1:0] var_r;
  logic [DW-1:0] lhs_r;
  logic [RW-1:0] rhs_r;
  logic          hit_r;

  // stage tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  // products of the scaled mean and variance terms
  always_ff @(posedge clk) begin
    np_r <= SW'(n) * SW'(price);
    nq_r <= DW'(sum_sq) * DW'(n);
    s2_r <= DW'(sum) * DW'(sum);
    p2_r <= PB'(mult) * PB'(mult);
  end

  // deviation magnitude and variance, clamped at zero
  always_ff @(posedge clk) begin
    if (vld_r[0]) begin
      dpos_r <= np_r >= sum;
      mag_r  <= (np_r >= sum) ? (np_r - sum) : (sum - np_r);
      var_r  <= (nq_r >= s2_r) ? (nq_r - s2_r) : '0;
    end
  end

  // squared deviation against scaled variance
  always_ff @(posedge clk) begin
    if (vld_r[1]) begin
      lhs_r <= DW'(mag_r) * DW'(mag_r);
      rhs_r <= RW'(var_r) * RW'(p2_r);
    end
    if (vld_r[2]) begin
      hit_r <= RW'(lhs_r) >= rhs_r;
    end
  end

  assign done = vld_r[3];
  assign dpos = dpos_r;
  assign hit  = hit_r;

endmodule

// ===== sv/rolling_band_trade_signal_top.sv =====
// rolling_band_trade_signal_top: sequencer, position ledger and output register of the band trader
// Takes one price word and returns one result word: the trade action, whether the window is
// full, net position, cash balance and marked-to-market value. Words are processed one at a
// time: the oldest price is read from the ring memory, replaced and the running sums updated,
// the band test runs through a four-stage multiply chain, then the ledger is updated and the
// mark formed. The result sits in an output register, so the next word is taken while it waits.
// The price memory needs no clearing after reset: a slot is only read back once it has been
// written since the window last restarted. Writing window_len restarts the window; position
// and balance are kept. Registers must be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module rolling_band_trade_signal_top #(
  parameter int MAX_WINDOW = 64,
  parameter int PRICE_BITS = 24
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [PRICE_BITS-1:0]                     in_price,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [1:0]                                out_action,
  output logic                                      out_window_ready,
  output logic signed [rbts_pkg::POS_BITS-1:0]      out_net_position,
  output logic signed [rbts_pkg::BAL_BITS-1:0]      out_cash_balance,
  output logic signed [rbts_pkg::BAL_BITS-1:0]      out_marked_value,
  input  logic                                      cfg_we,
  input  logic [rbts_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [rbts_pkg::CFG_DATA_BITS-1:0]        cfg_wdata
);

  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int SW     = PRICE_BITS + AW;
  localparam int QW     = 2 * PRICE_BITS + AW;
  localparam int POSW   = rbts_pkg::POS_BITS;
  localparam int BALW   = rbts_pkg::BAL_BITS;
  localparam int PRODW  = POSW + PRICE_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_UPD,
    S_BGO,
    S_BAND,
    S_MUL,
    S_MARK
  } state_t;

  state_t                             state_r;
  logic [rbts_pkg::WLEN_BITS-1:0]     wlen_r;
  logic [rbts_pkg::LIMIT_BITS-1:0]    limit_r;
  logic [rbts_pkg::MULT_BITS-1:0]     mult_r;
  logic [PRICE_BITS-1:0]              price_r;
  logic signed [POSW-1:0]             position_r;
  logic signed [BALW-1:0]             balance_r;
  rbts_pkg::action_t                  action_r;
  logic signed [PRODW-1:0]            prod_r;
  logic                               out_valid_r;
  rbts_pkg::action_t                  out_action_r;
  logic                               out_ready_r;
  logic signed [POSW-1:0]             out_pos_r;
  logic signed [BALW-1:0]             out_bal_r;
  logic signed [BALW-1:0]             out_mark_r;

  logic [NW-1:0]                      n;
  logic [31:0]                        wlen_ext;
  rbts_pkg::win_ctl_t                 win_ctl;
  logic [SW-1:0]                      win_sum;
  logic [QW-1:0]                      win_sum_sq;
  logic                               win_ready;
  logic                               band_done;
  logic                               band_dpos;
  logic                               band_hit;
  logic                               in_accept;
  logic                               out_free;
  logic signed [POSW-1:0]             limit_s;
  logic signed [BALW:0]               price_ext;
  logic signed [BALW:0]               bal_ext;
  logic signed [BALW:0]               mark_sum;

  // effective window length: zero acts as one, clamp at the store depth
  assign wlen_ext = 32'(wlen_r);
  always_comb begin
    if (wlen_ext == 32'd0) begin
      n = NW'(1);
    end else if (wlen_ext > 32'(MAX_WINDOW)) begin
      n = NW'(MAX_WINDOW);
    end else begin
      n = NW'(wlen_ext);
    end
  end

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // window store control
  assign win_ctl.load    = in_accept;
  assign win_ctl.update  = (state_r == S_UPD);
  assign win_ctl.restart = cfg_we && (cfg_index == rbts_pkg::CFG_WINDOW_LEN);

  rbts_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .n      (n),
    .price  (in_price),
    .sum    (win_sum),
    .sum_sq (win_sum_sq),
    .ready  (win_ready)
  );

  rbts_band #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_band (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_BGO),
    .n      (n),
    .price  (price_r),
    .sum    (win_sum),
    .sum_sq (win_sum_sq),
    .mult   (mult_r),
    .done   (band_done),
    .dpos   (band_dpos),
    .hit    (band_hit)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= rbts_pkg::WLEN_RESET;
      limit_r <= rbts_pkg::LIMIT_RESET;
      mult_r  <= rbts_pkg::MULT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbts_pkg::CFG_WINDOW_LEN: wlen_r  <= cfg_wdata[rbts_pkg::WLEN_BITS-1:0];
        rbts_pkg::CFG_POS_LIMIT:  limit_r <= cfg_wdata[rbts_pkg::LIMIT_BITS-1:0];
        rbts_pkg::CFG_BAND_MULT:  mult_r  <= cfg_wdata[rbts_pkg::MULT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ledger arithmetic
  assign limit_s   = $signed({1'b0, limit_r});
  assign price_ext = $signed((BALW+1)'(price_r));
  assign bal_ext   = (BALW+1)'(balance_r);
  assign mark_sum  = (BALW+1)'(balance_r) + (BALW+1)'(prod_r);

  // price latch and mark product
  always_ff @(posedge clk) begin
    if (in_accept) begin
      price_r <= in_price;
    end
    if (state_r == S_MUL) begin
      prod_r <= position_r * $signed({1'b0, price_r});
    end
  end

  // sequencer, ledger and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      position_r  <= '0;
      balance_r   <= '0;
      action_r    <= rbts_pkg::ACT_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_SQ;
          end
        end
        S_SQ:  state_r <= S_UPD;
        S_UPD: state_r <= S_BGO;
        S_BGO: state_r <= S_BAND;
        S_BAND: begin
          if (band_done) begin
            action_r <= rbts_pkg::ACT_HOLD;
            if (win_ready && band_hit) begin
              if (band_dpos) begin
                if (position_r < limit_s) begin
                  action_r   <= rbts_pkg::ACT_BUY;
                  position_r <= position_r + POSW'(1);
                  balance_r  <= rbts_pkg::sat_bal(bal_ext - price_ext);
                end
              end else if (position_r > -limit_s) begin
                action_r   <= rbts_pkg::ACT_SELL;
                position_r <= position_r - POSW'(1);
                balance_r  <= rbts_pkg::sat_bal(bal_ext + price_ext);
              end
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_MARK;
        S_MARK: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_action_r <= action_r;
            out_ready_r  <= win_ready;
            out_pos_r    <= position_r;
            out_bal_r    <= balance_r;
            out_mark_r   <= rbts_pkg::sat_bal(mark_sum);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_window_ready = out_ready_r;
  assign out_net_position = out_pos_r;
  assign out_cash_balance = out_bal_r;
  assign out_marked_value = out_mark_r;

  // the band result only arrives while the sequencer waits for it
  a_band_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    band_done |-> (state_r == S_BAND))
    else $error("band result outside its step");

  // a trade is only reported once the window is full
  a_trade_needs_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r != rbts_pkg::ACT_HOLD)) |-> out_ready_r)
    else $error("trade before window filled");

endmodule

// ===== test/rolling_band_trade_signal_top_tb.sv =====
// rolling_band_trade_signal_top_tb: self-checking bench for the band trader with its own ledger copy
`timescale 1ns / 1ps

module rolling_band_trade_signal_top_tb;

  localparam int     WINDOW_CAP     = 64;
  localparam int     PRICE_W        = 24;
  localparam int     PRICE_TOP      = (1 << PRICE_W) - 1;
  localparam longint BAL_TOP        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint BAL_BOTTOM     = -BAL_TOP - 1;
  localparam int     SETTLE_CYCLES  = 16;
  localparam int     RANDOM_PHASES  = 12;
  // register index that the block does not decode
  localparam logic [rbts_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  // shapes of generated price series
  typedef enum int {
    FEED_NOISE,
    FEED_FLAT,
    FEED_DRIFT,
    FEED_SPIKY
  } feed_style_t;

  // one result word as the ledger copy predicts it
  typedef struct packed {
    rbts_pkg::action_t             action;
    logic                          ready;
    logic [rbts_pkg::POS_BITS-1:0] pos;
    logic [rbts_pkg::BAL_BITS-1:0] cash;
    logic [rbts_pkg::BAL_BITS-1:0] marked;
  } trade_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PRICE_W-1:0] in_price = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_action;
  logic out_window_ready;
  logic signed [rbts_pkg::POS_BITS-1:0] out_net_position;
  logic signed [rbts_pkg::BAL_BITS-1:0] out_cash_balance;
  logic signed [rbts_pkg::BAL_BITS-1:0] out_marked_value;
  logic cfg_we = 1'b0;
  logic [rbts_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [rbts_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // stimulus and scoreboard
  logic [PRICE_W-1:0] pending_prices[$];
  trade_word_t due_words[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // price series generator state
  feed_style_t feed_style = FEED_SPIKY;
  int walk_level = 1000000;
  int drift = 0;

  // ledger copy: configuration
  logic [rbts_pkg::WLEN_BITS-1:0]  wlen_cfg  = rbts_pkg::WLEN_RESET;
  logic [rbts_pkg::LIMIT_BITS-1:0] limit_cfg = rbts_pkg::LIMIT_RESET;
  logic [rbts_pkg::MULT_BITS-1:0]  mult_cfg  = rbts_pkg::MULT_RESET;

  // ledger copy: window and book
  logic [PRICE_W-1:0] win_mem[WINDOW_CAP];
  int unsigned fill_cnt = 0;
  int unsigned win_ptr = 0;
  logic [127:0] run_sum = '0;
  logic [127:0] run_sq = '0;
  int pos_now = 0;
  longint bal_now = 0;

  rolling_band_trade_signal_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_price         (in_price),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_action       (out_action),
    .out_window_ready (out_window_ready),
    .out_net_position (out_net_position),
    .out_cash_balance (out_cash_balance),
    .out_marked_value (out_marked_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // clamp to the 48-bit cash range
  function automatic longint clamp48(input longint v);
    if (v > BAL_TOP) return BAL_TOP;
    if (v < BAL_BOTTOM) return BAL_BOTTOM;
    return v;
  endfunction

  // advance the window and book by one price and queue the word it should give
  function automatic void predict_tick(input logic [PRICE_W-1:0] price);
    int unsigned n;
    logic [PRICE_W-1:0] oldest;
    logic [127:0] np, mag, nq, s2, spread, lhs, rhs;
    logic dpos, band_hit, ready;
    rbts_pkg::action_t act;
    longint mark;
    trade_word_t w;
    n = (wlen_cfg == 0) ? 1 : (wlen_cfg > WINDOW_CAP) ? WINDOW_CAP : int'(wlen_cfg);
    if (win_ptr >= n) win_ptr = 0;
    // drop the oldest sample once the window is full
    if (fill_cnt >= n) begin
      oldest = win_mem[win_ptr];
      run_sum = run_sum - 128'(oldest);
      run_sq = run_sq - 128'(oldest) * 128'(oldest);
    end else begin
      fill_cnt++;
    end
    win_mem[win_ptr] = price;
    run_sum = run_sum + 128'(price);
    run_sq = run_sq + 128'(price) * 128'(price);
    win_ptr = (win_ptr + 1 >= n) ? 0 : win_ptr + 1;
    ready = (fill_cnt >= n);
    act = rbts_pkg::ACT_HOLD;
    // squared band test: (n*p - sum)^2 against mult^2 * (n*sumsq - sum^2)
    if (ready) begin
      np = 128'(n) * 128'(price);
      dpos = (np >= run_sum);
      mag = dpos ? np - run_sum : run_sum - np;
      nq = run_sq * 128'(n);
      s2 = run_sum * run_sum;
      spread = (nq >= s2) ? nq - s2 : '0;
      lhs = mag * mag;
      rhs = spread * (128'(mult_cfg) * 128'(mult_cfg));
      band_hit = (lhs >= rhs);
      if (dpos && band_hit) begin
        if (pos_now < int'(limit_cfg)) begin
          act = rbts_pkg::ACT_BUY;
          pos_now++;
          bal_now = clamp48(bal_now - longint'(price));
        end
      end else if (band_hit) begin
        if (pos_now > -int'(limit_cfg)) begin
          act = rbts_pkg::ACT_SELL;
          pos_now--;
          bal_now = clamp48(bal_now + longint'(price));
        end
      end
    end
    mark = clamp48(bal_now + longint'(pos_now) * longint'(price));
    w.action = act;
    w.ready = ready;
    w.pos = rbts_pkg::POS_BITS'(pos_now);
    w.cash = rbts_pkg::BAL_BITS'(bal_now);
    w.marked = rbts_pkg::BAL_BITS'(mark);
    due_words = {due_words, w};
  endfunction

  // next sample of the current price series
  function automatic logic [PRICE_W-1:0] next_price();
    int r;
    int step;
    r = $urandom_range(99);
    case (feed_style)
      FEED_NOISE: walk_level = int'($urandom_range(PRICE_TOP));
      FEED_FLAT: begin
        if (r < 8) walk_level = int'($urandom_range(PRICE_TOP));
      end
      FEED_DRIFT: walk_level = walk_level + drift + int'($urandom_range(64)) - 32;
      default: begin
        step = (r < 12) ? 200000 : 300;
        walk_level = walk_level + int'($urandom_range(2 * step)) - step;
      end
    endcase
    // occasional extremes
    if (r == 99) walk_level = 0;
    else if (r == 98) walk_level = PRICE_TOP;
    if (walk_level < 0) walk_level = 0;
    if (walk_level > PRICE_TOP) walk_level = PRICE_TOP;
    return PRICE_W'(walk_level);
  endfunction

  // register write, mirrored into the ledger copy
  task automatic write_reg(input logic [rbts_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [rbts_pkg::CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rbts_pkg::CFG_WINDOW_LEN: begin
        wlen_cfg = val[rbts_pkg::WLEN_BITS-1:0];
        fill_cnt = 0;
        win_ptr = 0;
        run_sum = '0;
        run_sq = '0;
      end
      rbts_pkg::CFG_POS_LIMIT: limit_cfg = val[rbts_pkg::LIMIT_BITS-1:0];
      rbts_pkg::CFG_BAND_MULT: mult_cfg = val[rbts_pkg::MULT_BITS-1:0];
      default: ;
    endcase
  endtask

  // hold off until every word is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_prices.size() != 0 || in_valid || due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // queue a list of prices and let them run through
  task automatic run_prices(input logic [PRICE_W-1:0] prices[$]);
    @(negedge clk);
    foreach (prices[k]) pending_prices = {pending_prices, prices[k]};
    wait_drained();
  endtask

  // driver: present queued prices, hold a stalled word steady
  always @(posedge clk) begin
    logic advance;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      advance = !in_valid;
      if (in_valid && !in_stall) begin
        predict_tick(in_price);
        advance = 1'b1;
      end
      if (advance) begin
        if (pending_prices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_price <= pending_prices.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result word with the oldest one due
  always @(posedge clk) begin
    trade_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word arrived with none due", $realtime);
        end else begin
          want = due_words.pop_front();
          if (out_action !== want.action || out_window_ready !== want.ready ||
              out_net_position !== want.pos || out_cash_balance !== want.cash ||
              out_marked_value !== want.marked) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp act=%0d rdy=%0d pos=%0d cash=%0d mark=%0d",
                       $realtime, want.action, want.ready, $signed(want.pos),
                       $signed(want.cash), $signed(want.marked));
              $display("%0t:          got act=%0d rdy=%0d pos=%0d cash=%0d mark=%0d",
                       $realtime, out_action, out_window_ready, out_net_position,
                       out_cash_balance, out_marked_value);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // stimulus: directed cases first, then random phases
  initial begin
    logic [PRICE_W-1:0] batch[$];
    logic [rbts_pkg::CFG_DATA_BITS-1:0] v;
    int count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: window fills on flat prices, price equal to mean buys
    run_prices('{24'd1000, 24'd1000, 24'd1000, 24'd1000, 24'd1000, 24'd1000});

    // limit below current position: buys blocked, sells down to the limit then hold
    write_reg(rbts_pkg::CFG_BAND_MULT, 10'd0);
    write_reg(rbts_pkg::CFG_POS_LIMIT, 10'd0);
    run_prices('{24'hFFFFFF, 24'd0, 24'd0, 24'd0});

    // zero window length acts as one, widest multiplier
    write_reg(rbts_pkg::CFG_WINDOW_LEN, 10'd0);
    write_reg(rbts_pkg::CFG_POS_LIMIT, 10'd1023);
    write_reg(rbts_pkg::CFG_BAND_MULT, 10'd15);
    run_prices('{24'd0, 24'hFFFFFF, 24'd123});

    // restart with a short window; undecoded index is ignored
    write_reg(rbts_pkg::CFG_WINDOW_LEN, 10'd3);
    write_reg(CFG_UNUSED_IDX, 10'h3FF);
    run_prices('{24'd100, 24'd100, 24'd100, 24'd5000});

    // oversize window length acts as the largest window
    write_reg(rbts_pkg::CFG_WINDOW_LEN, 10'd127);
    write_reg(rbts_pkg::CFG_BAND_MULT, 10'd1);
    write_reg(rbts_pkg::CFG_POS_LIMIT, 10'd3);
    run_prices('{24'hFFFFFF, 24'd0});

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // idling pattern of this phase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase

      // window length, sometimes kept so the window carries over
      if (ph == 0 || $urandom_range(2) != 0) begin
        case ($urandom_range(9))
          0: v = 10'd0;
          1: v = 10'd1;
          2: v = 10'd64;
          3: v = 10'd127;
          4, 5: v = 10'($urandom_range(8, 2));
          6, 7: v = 10'($urandom_range(64, 9));
          8: v = 10'($urandom_range(127, 65));
          default: v = 10'($urandom);
        endcase
        v[rbts_pkg::CFG_DATA_BITS-1:rbts_pkg::WLEN_BITS] = 3'($urandom);
        write_reg(rbts_pkg::CFG_WINDOW_LEN, v);
      end
      case ($urandom_range(5))
        0: v = 10'd0;
        1: v = 10'd1;
        2: v = 10'd1023;
        default: v = 10'($urandom_range(12, 2));
      endcase
      write_reg(rbts_pkg::CFG_POS_LIMIT, v);
      case ($urandom_range(4))
        0: v = 10'd0;
        1: v = 10'd15;
        default: v = 10'($urandom_range(4, 1));
      endcase
      v[rbts_pkg::CFG_DATA_BITS-1:rbts_pkg::MULT_BITS] = 6'($urandom);
      write_reg(rbts_pkg::CFG_BAND_MULT, v);
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, 10'($urandom));

      // price series shape, mostly structured
      case ($urandom_range(4))
        0: feed_style = FEED_NOISE;
        1: feed_style = FEED_FLAT;
        2: feed_style = FEED_DRIFT;
        default: feed_style = FEED_SPIKY;
      endcase
      drift = int'($urandom_range(4000)) - 2000;
      walk_level = int'($urandom_range(PRICE_TOP));

      count = $urandom_range(160, 100);
      batch.delete();
      repeat (count) batch = {batch, next_price()};
      run_prices(batch);
    end

    if (mismatches == 0 && due_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
